/* rtl/smpq_pkg.sv */
// Shared types and codes for the sorted max-priority queue.
// Used by the front queue, the back sorted store and the top level.
package smpq_pkg;

  // Operation carried from front to back
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OCC_W   = 5;

  // One word in the front-to-back queue
  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } op_word_t;

endpackage

/* rtl/smpq_front.sv */
// Front part: accepts input words, classifies them into operations and
// holds them in a two-entry queue for the back part. Depends on smpq_pkg.
module smpq_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic signed [smpq_pkg::VALUE_W-1:0] push_value,
  output logic                               q_valid,
  input  logic                               q_ready,
  output smpq_pkg::op_word_t                 q_word
);

  localparam int unsigned QD = 2;

  smpq_pkg::op_word_t q_mem [QD];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         level;
  logic               push_q;
  logic               pop_q;
  smpq_pkg::op_word_t in_word;

  // Classify the incoming word
  always_comb begin
    in_word.op    = mode ? smpq_pkg::OP_POP : smpq_pkg::OP_PUSH;
    in_word.value = push_value;
  end

  assign in_ready = (level != 2'(QD));
  assign q_valid  = (level != 2'd0);
  assign q_word   = q_mem[rd_ptr];
  assign push_q   = in_valid && in_ready;
  assign pop_q    = q_valid && q_ready;

  // Queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_q) begin
      q_mem[wr_ptr] <= in_word;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push_q) wr_ptr <= ~wr_ptr;
      if (pop_q)  rd_ptr <= ~rd_ptr;
      case ({push_q, pop_q})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= 2'(QD))
    else $error("front queue level out of range");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (level == 2'(QD) || level == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("front queue pointers disagree with level");

  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    (push_q && !pop_q) |=> (level == $past(level) + 2'd1))
    else $error("front queue level did not grow on write");

endmodule

/* rtl/smpq_back.sv */
// Back part: the sorted store as a row of compare-and-shift cells, kept
// largest first, plus the result register. Depends on smpq_pkg.
module smpq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  smpq_pkg::op_word_t                  q_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smpq_pkg::VALUE_W-1:0] popped_value,
  output smpq_pkg::status_t                   status,
  output logic [smpq_pkg::OCC_W-1:0]          occupancy
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [smpq_pkg::VALUE_W-1:0] cells      [DEPTH];
  logic signed [smpq_pkg::VALUE_W-1:0] cells_next [DEPTH];
  logic [CW-1:0]                       count;
  logic [CW-1:0]                       count_next;
  logic [DEPTH-1:0]                    gt;
  logic [DEPTH-1:0]                    gt_prev;
  logic                                take;
  logic                                full;
  logic                                empty;
  logic                                is_push;
  logic signed [smpq_pkg::VALUE_W-1:0] res_value_next;
  smpq_pkg::status_t                   res_status_next;

  assign q_ready = !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign is_push = (q_word.op == smpq_pkg::OP_PUSH);

  // Per-cell compare: new word goes above any cell it beats or any empty cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) >= count) || (q_word.value > cells[i]);
    end
    gt_prev = {gt[DEPTH-2:0], 1'b0};
  end

  // Cell update: insert/shift down on push, shift up on pop
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_next[i] = cells[i];
      if (take && is_push && !full) begin
        if (gt[i] && !gt_prev[i]) begin
          cells_next[i] = q_word.value;
        end else if (gt[i] && i > 0) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (take && !is_push && !empty) begin
        if (i < DEPTH - 1) begin
          cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Count and result word
  always_comb begin
    count_next      = count;
    res_value_next  = '0;
    res_status_next = smpq_pkg::ST_OK;
    if (is_push) begin
      if (full) begin
        res_status_next = smpq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        res_status_next = smpq_pkg::ST_EMPTY;
      end else begin
        res_value_next = cells[0];
        count_next     = count - CW'(1);
      end
    end
  end

  // Sorted cells, no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  // Count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (take) begin
      popped_value <= res_value_next;
      status       <= res_status_next;
      occupancy    <= smpq_pkg::OCC_W'(count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count exceeds depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (take && !is_push && empty) |=>
      (status == smpq_pkg::ST_EMPTY && popped_value == '0 && count == '0))
    else $error("pop on empty queue misreported");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (take && is_push && full) |=> (status == smpq_pkg::ST_FULL && $stable(count)))
    else $error("push on full queue changed the store");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (cells[0] >= cells[1]))
    else $error("top cells out of order");

endmodule

/* rtl/sorted_max_priority_queue_core.sv */
// Sorted max-priority queue: one result word per input word.
// An accepted input word is held in the front queue, then the cell row registers its result.
// Throughput: one word per cycle; the cell row compares and shifts all entries
// combinationally, so only the output handshake can slow the block.
// Reset (synchronous, rst high) empties the store, front queue and result register;
// cell data is not cleared.
module sorted_max_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic signed [smpq_pkg::VALUE_W-1:0] push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smpq_pkg::VALUE_W-1:0] popped_value,
  output logic [1:0]                          status,
  output logic [smpq_pkg::OCC_W-1:0]          occupancy
);

  logic               q_valid;
  logic               q_ready;
  smpq_pkg::op_word_t q_word;
  smpq_pkg::status_t  status_code;

  // Front: accept and classify
  smpq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .push_value (push_value),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_word     (q_word)
  );

  // Back: sorted cell row and result register
  smpq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_word       (q_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .status       (status_code),
    .occupancy    (occupancy)
  );

  assign status = status_code;

endmodule

/* test/tb_sorted_max_priority_queue_core.sv */
// Testbench for sorted_max_priority_queue_core: push/pop words with a scoreboard.
// Depends on rtl/smpq_pkg.sv and rtl/sorted_max_priority_queue_core.sv.
`timescale 1ns / 100ps

module tb_sorted_max_priority_queue_core;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_WORDS = 750;

  // One expected result word
  typedef struct {
    logic signed [smpq_pkg::VALUE_W-1:0] value;
    smpq_pkg::status_t                   st;
    logic [smpq_pkg::OCC_W-1:0]          occ;
  } pq_result_t;

  // Scoreboard: keeps its own sorted store and the queue of expected results
  class pq_scoreboard;
    logic signed [smpq_pkg::VALUE_W-1:0] held[QUEUE_DEPTH];
    int held_count;
    pq_result_t pending[$];
    int errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    // Predict the result of an accepted input word
    function void note_word(smpq_pkg::op_t op, logic signed [smpq_pkg::VALUE_W-1:0] val);
      pq_result_t r;
      int pos;
      int i;
      r.value = '0;
      r.st = smpq_pkg::ST_OK;
      if (op == smpq_pkg::OP_PUSH) begin
        if (held_count >= QUEUE_DEPTH) begin
          r.st = smpq_pkg::ST_FULL;
        end else begin
          // new value goes below every equal entry
          pos = 0;
          while (pos < held_count && val > held[pos]) pos++;
          for (i = held_count; i > pos; i--) held[i] = held[i-1];
          held[pos] = val;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.st = smpq_pkg::ST_EMPTY;
        end else begin
          held_count--;
          r.value = held[held_count];
        end
      end
      r.occ = smpq_pkg::OCC_W'(held_count);
      pending.push_back(r);
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare an accepted result word with the oldest prediction
    function void check_word(logic signed [smpq_pkg::VALUE_W-1:0] val, logic [1:0] st,
                             logic [smpq_pkg::OCC_W-1:0] occ);
      pq_result_t want;
      if (pending.size() == 0) begin
        log_error($sformatf("unexpected word: value %0d status %0d occupancy %0d",
                            val, st, occ));
        return;
      end
      want = pending.pop_front();
      if (val !== want.value || st !== want.st || occ !== want.occ)
        log_error($sformatf({"mismatch: expected value %0d status %0d occupancy %0d,",
                             " got value %0d status %0d occupancy %0d"},
                            want.value, want.st, want.occ, val, st, occ));
    endfunction

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic                                mode;
  logic signed [smpq_pkg::VALUE_W-1:0] push_value;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [smpq_pkg::VALUE_W-1:0] popped_value;
  logic [1:0]                          status;
  logic [smpq_pkg::OCC_W-1:0]          occupancy;

  logic steady;  // no idling on either side while set

  pq_scoreboard sb = new();

  sorted_max_priority_queue_core #(
    .DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .popped_value(popped_value),
    .status(status),
    .occupancy(occupancy)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls about 21% of cycles unless in a steady stretch
  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= 21);
  end

  // Monitors: note accepted inputs, check accepted results
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(popped_value, status, occupancy);
    if (!rst && in_valid && in_ready) sb.note_word(smpq_pkg::op_t'(mode), push_value);
  end

  // Drive one word; called and returns at a falling edge
  task automatic send_word(smpq_pkg::op_t op, logic signed [smpq_pkg::VALUE_W-1:0] val);
    while (!steady && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode = op;
    push_value = val;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  // Mix of wide random values, small clustered values and extremes
  function automatic logic signed [smpq_pkg::VALUE_W-1:0] pick_value();
    logic signed [smpq_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      5, 6: v = $signed($urandom_range(15)) - 8;
      7: begin
        case ($urandom_range(3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    int i;
    int push_pct;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = smpq_pkg::OP_PUSH;
    push_value = '0;
    steady = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty pop, extremes, equal values, fill to full, dropped push
    send_word(smpq_pkg::OP_POP, $urandom);
    send_word(smpq_pkg::OP_PUSH, 32'sh7fffffff);
    send_word(smpq_pkg::OP_PUSH, 32'sh80000000);
    send_word(smpq_pkg::OP_PUSH, 0);
    send_word(smpq_pkg::OP_PUSH, -1);
    send_word(smpq_pkg::OP_PUSH, 0);
    send_word(smpq_pkg::OP_PUSH, 32'sh7fffffff);
    send_word(smpq_pkg::OP_POP, 0);
    send_word(smpq_pkg::OP_POP, 0);
    send_word(smpq_pkg::OP_POP, 0);
    for (i = 0; i < 13; i++) send_word(smpq_pkg::OP_PUSH, pick_value());
    send_word(smpq_pkg::OP_PUSH, 32'sh12345678);
    send_word(smpq_pkg::OP_POP, 0);

    // Random: push bias changes every 50 words to sweep between empty and full
    push_pct = 50;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(4))
          0: push_pct = 85;
          1: push_pct = 15;
          2: push_pct = 55;
          3: push_pct = 95;
          default: push_pct = 5;
        endcase
      end
      steady = (i >= 300 && i < 450);
      if (i == 500) begin
        // hold off until the block has drained
        in_valid = 1'b0;
        while (sb.pending_count() != 0) @(negedge clk);
      end
      if ($urandom_range(99) < push_pct) send_word(smpq_pkg::OP_PUSH, pick_value());
      else send_word(smpq_pkg::OP_POP, $urandom);
    end
    in_valid = 1'b0;
    steady = 1'b0;

    while (sb.pending_count() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
